FILE: hdl/uges_pkg.sv
// Package with the item types, operation codes and default sizes of the graph edge store.
package uges_pkg;

    localparam int MAX_VERTICES_DEFAULT = 16;

    localparam int KIND_W = 2;
    localparam int VERTEX_W = 4;
    localparam int EDGE_COUNT_W = 7;
    localparam int VERTEX_COUNT_W = 5;

    localparam logic [VERTEX_COUNT_W-1:0] INITIAL_VERTICES_RESET = 5'd16;

    localparam logic [KIND_W-1:0] KIND_INSERT_EDGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE_EDGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_VERTEX = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VERTEX_W-1:0] first_vertex;
        logic [VERTEX_W-1:0] second_vertex;
    } in_item_t;

    typedef struct packed {
        logic                      applied;
        logic [EDGE_COUNT_W-1:0]   edge_count;
        logic [VERTEX_COUNT_W-1:0] vertex_count;
    } out_item_t;

endpackage

FILE: hdl/uges_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module uges_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/undirected_graph_edge_store.sv
// Top level of the undirected graph edge store: adjacency matrix in RAM and its sequencer.
//
// The block keeps a simple undirected graph as a symmetric adjacency matrix, one RAM row per
// vertex, plus an edge counter and a count of removed vertices. Each input item inserts an
// edge, removes an edge or removes a vertex, and yields exactly one result item with an
// applied flag, the edge count and the live vertex count. Items are handled one at a time.
// An edge insert or removal reads the first endpoint's row, checks the edge bit, then writes
// both rows back, stepping through READ_A, CHECK, WRITE_B and FINISH, where its result is
// loaded. A duplicate insert, a self-loop insert or the removal of an absent edge stops after
// the check and goes straight to FINISH. A vertex removal sweeps the matrix one row per cycle
// through the RAM's single read and write ports, shifting rows and columns down and counting
// the removed vertex's degree on the way, then writes its last row in DRAIN before FINISH. An
// item that fails the range check or has an unused kind goes from idle straight to FINISH.
// The block returns to idle as each result is loaded. While the previous result still waits
// for m_ready, the block holds in FINISH and the next accept waits with it. Writing
// cfg_wr_data with cfg_wr_en restarts the graph empty; the matrix needs no clearing pass,
// since a valid bit per row makes rows not yet written read as zero.
module undirected_graph_edge_store #(
    parameter int MAX_VERTICES = uges_pkg::MAX_VERTICES_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  uges_pkg::in_item_t                      s_item,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output uges_pkg::out_item_t                     m_item,
    input  logic                                    cfg_wr_en,
    input  logic [uges_pkg::VERTEX_COUNT_W-1:0]     cfg_wr_data
);

    localparam int RW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int LW = (CW > uges_pkg::VERTEX_COUNT_W) ? CW : uges_pkg::VERTEX_COUNT_W;
    localparam int EDGE_MAX = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
    localparam int EW0 = $clog2(EDGE_MAX + 1);
    localparam int EW = (EW0 > uges_pkg::EDGE_COUNT_W) ? EW0 : uges_pkg::EDGE_COUNT_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ_A = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_WRITE_B = 7'b0001000,
        ST_SWEEP  = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                               state_reg, state_next;
    logic [uges_pkg::KIND_W-1:0]          kind_reg, kind_next;
    logic [uges_pkg::VERTEX_W-1:0]        a_reg, a_next;
    logic [uges_pkg::VERTEX_W-1:0]        b_reg, b_next;
    logic                                 applied_reg, applied_next;
    logic [EW-1:0]                        edges_reg, edges_next;
    logic [CW-1:0]                        removed_reg, removed_next;
    logic [uges_pkg::VERTEX_COUNT_W-1:0]  init_reg, init_next;
    logic [MAX_VERTICES-1:0]              row_valid_reg, row_valid_next;
    logic [RW-1:0]                        k_reg, k_next;
    logic                                 pend_reg, pend_next;
    logic [RW-1:0]                        pend_dst_reg, pend_dst_next;
    logic [CW-1:0]                        deg_reg, deg_next;
    logic                                 rd_ok_reg, rd_ok_next;
    logic                                 m_valid_reg, m_valid_next;
    uges_pkg::out_item_t                  m_item_reg, m_item_next;

    logic [LW-1:0]           init_ext;
    logic [LW-1:0]           max_ext;
    logic [LW-1:0]           base_count;
    logic [LW-1:0]           removed_ext;
    logic [LW-1:0]           live_count;
    logic                    s_a_ok;
    logic                    s_b_ok;
    logic [RW-1:0]           a_idx;
    logic [RW-1:0]           b_idx;
    logic [RW:0]             sweep_src;
    logic                    sweep_zero;
    logic                    ram_we;
    logic [RW-1:0]           ram_waddr;
    logic [MAX_VERTICES-1:0] ram_wdata;
    logic [RW-1:0]           ram_raddr;
    logic                    rd_zero;
    logic [MAX_VERTICES-1:0] ram_rdata;
    logic [MAX_VERTICES-1:0] rd_row;
    logic [MAX_VERTICES-1:0] rd_row_shift;
    logic [MAX_VERTICES-1:0] drop_row;
    logic [MAX_VERTICES-1:0] mask_a;
    logic [MAX_VERTICES-1:0] mask_b;
    logic                    edge_bit;
    logic [CW-1:0]           deg_total;

    uges_ram #(
        .WIDTH(MAX_VERTICES),
        .DEPTH(MAX_VERTICES)
    ) u_matrix (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign init_ext = LW'(init_reg);
    assign max_ext = LW'(MAX_VERTICES);
    assign base_count = (init_ext > max_ext) ? max_ext : init_ext;
    assign removed_ext = LW'(removed_reg);
    assign live_count = (removed_ext >= base_count) ? '0 : base_count - removed_ext;

    assign s_a_ok = LW'(s_item.first_vertex) < live_count;
    assign s_b_ok = LW'(s_item.second_vertex) < live_count;

    assign a_idx = RW'(a_reg);
    assign b_idx = RW'(b_reg);

    assign sweep_src = (k_reg < a_idx) ? {1'b0, k_reg} : {1'b0, k_reg} + (RW+1)'(1);
    assign sweep_zero = sweep_src == (RW+1)'(MAX_VERTICES);

    assign rd_row = rd_ok_reg ? ram_rdata : '0;
    assign rd_row_shift = rd_row >> 1;
    assign mask_a = MAX_VERTICES'(1) << a_idx;
    assign mask_b = MAX_VERTICES'(1) << b_idx;
    assign edge_bit = rd_row[b_idx];
    assign deg_total = deg_reg + CW'(rd_row[a_idx]);

    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            drop_row[j] = (RW'(j) < a_idx) ? rd_row[j] : rd_row_shift[j];
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;

    always_comb begin
        state_next = state_reg;
        kind_next = kind_reg;
        a_next = a_reg;
        b_next = b_reg;
        applied_next = applied_reg;
        edges_next = edges_reg;
        removed_next = removed_reg;
        init_next = init_reg;
        row_valid_next = row_valid_reg;
        k_next = k_reg;
        pend_next = 1'b0;
        pend_dst_next = pend_dst_reg;
        deg_next = deg_reg;
        m_valid_next = m_valid_reg;
        m_item_next = m_item_reg;
        ram_we = 1'b0;
        ram_waddr = a_idx;
        ram_wdata = drop_row;
        ram_raddr = a_idx;
        rd_zero = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_item.kind;
                    a_next = s_item.first_vertex;
                    b_next = s_item.second_vertex;
                    applied_next = 1'b0;
                    deg_next = '0;
                    k_next = '0;
                    state_next = ST_FINISH;
                    unique case (s_item.kind) inside
                        uges_pkg::KIND_INSERT_EDGE, uges_pkg::KIND_REMOVE_EDGE: begin
                            if (s_a_ok && s_b_ok) begin
                                state_next = ST_READ_A;
                            end
                        end
                        uges_pkg::KIND_REMOVE_VERTEX: begin
                            if (s_a_ok) begin
                                state_next = ST_SWEEP;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_READ_A: begin
                ram_raddr = a_idx;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                ram_raddr = b_idx;
                ram_waddr = a_idx;
                state_next = ST_FINISH;
                if (kind_reg == uges_pkg::KIND_INSERT_EDGE) begin
                    ram_wdata = rd_row | mask_b;
                    if (!edge_bit && (a_idx != b_idx)) begin
                        ram_we = 1'b1;
                        applied_next = 1'b1;
                        edges_next = edges_reg + EW'(1);
                        state_next = ST_WRITE_B;
                    end
                end else begin
                    ram_wdata = rd_row & ~mask_b;
                    if (edge_bit) begin
                        ram_we = 1'b1;
                        applied_next = 1'b1;
                        if (edges_reg != '0) begin
                            edges_next = edges_reg - EW'(1);
                        end
                        state_next = ST_WRITE_B;
                    end
                end
            end
            ST_WRITE_B: begin
                ram_we = 1'b1;
                ram_waddr = b_idx;
                ram_wdata = (kind_reg == uges_pkg::KIND_INSERT_EDGE) ?
                            (rd_row | mask_a) : (rd_row & ~mask_a);
                state_next = ST_FINISH;
            end
            ST_SWEEP: begin
                ram_raddr = sweep_src[RW-1:0];
                rd_zero = sweep_zero;
                pend_next = 1'b1;
                pend_dst_next = k_reg;
                if (pend_reg) begin
                    ram_we = 1'b1;
                    ram_waddr = pend_dst_reg;
                    ram_wdata = drop_row;
                    deg_next = deg_total;
                end
                k_next = k_reg + RW'(1);
                if (k_reg == RW'(MAX_VERTICES - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                ram_we = 1'b1;
                ram_waddr = pend_dst_reg;
                ram_wdata = drop_row;
                edges_next = (EW'(deg_total) > edges_reg) ? '0 : edges_reg - EW'(deg_total);
                removed_next = removed_reg + CW'(1);
                applied_next = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next.applied = applied_reg;
                    m_item_next.edge_count = edges_reg[uges_pkg::EDGE_COUNT_W-1:0];
                    m_item_next.vertex_count = live_count[uges_pkg::VERTEX_COUNT_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        rd_ok_next = row_valid_reg[ram_raddr] && !rd_zero;

        if (ram_we) begin
            row_valid_next[ram_waddr] = 1'b1;
        end

        if (cfg_wr_en) begin
            init_next = cfg_wr_data;
            edges_next = '0;
            removed_next = '0;
            row_valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            edges_reg <= '0;
            removed_reg <= '0;
            init_reg <= uges_pkg::INITIAL_VERTICES_RESET;
            row_valid_reg <= '0;
            pend_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            edges_reg <= edges_next;
            removed_reg <= removed_next;
            init_reg <= init_next;
            row_valid_reg <= row_valid_next;
            pend_reg <= pend_next;
            rd_ok_reg <= rd_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        a_reg <= a_next;
        b_reg <= b_next;
        applied_reg <= applied_next;
        k_reg <= k_next;
        pend_dst_reg <= pend_dst_next;
        deg_reg <= deg_next;
        m_item_reg <= m_item_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && ram_we) |-> (ram_waddr != ram_raddr || rd_zero))
        else $error("Sweep writes the row that it is reading.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE_B) |-> $past(state_reg == ST_CHECK && ram_we))
        else $error("Second row written without a first row write.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        edges_reg <= EW'(EDGE_MAX))
        else $error("Edge count exceeds a complete graph.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        removed_reg <= CW'(MAX_VERTICES))
        else $error("More vertices removed than the matrix holds.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (state_reg != ST_IDLE || $past(state_reg) != ST_FINISH))
        else $error("Result overwritten while the previous item was still waiting.");

endmodule
